### rtl/core/bdf_pkg.sv
`timescale 1ns / 1ps

package bdf_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned SIZE_W    = 4;
  localparam logic [DATA_W-1:0] DASH_CODE = 8'd45;

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_e;

  typedef enum logic {
    QUEUE_A = 1'b0,
    QUEUE_B = 1'b1
  } queue_sel_e;

  // command from the arbiter to one queue
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [DATA_W-1:0] data;
  } q_cmd_t;

  // head and tail bytes of one queue
  typedef struct packed {
    logic [DATA_W-1:0] head;
    logic [DATA_W-1:0] tail;
  } q_ends_t;

  // result beat, lowest field last
  typedef struct packed {
    logic [DATA_W-1:0] back_b;
    logic [DATA_W-1:0] front_b;
    logic [DATA_W-1:0] back_a;
    logic [DATA_W-1:0] front_a;
    logic [SIZE_W-1:0] size_b;
    logic [SIZE_W-1:0] size_a;
    logic [DATA_W-1:0] value_out;
  } res_data_t;

endpackage

### rtl/core/bdf_queue.sv
`timescale 1ns / 1ps

module bdf_queue #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned CW    = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bdf_pkg::q_cmd_t      cmd_i,
  output logic [CW-1:0]        count_o,
  output logic [CW-1:0]        count_next_o,
  output bdf_pkg::q_ends_t     ends_o,
  output bdf_pkg::q_ends_t     ends_next_o
);
  import bdf_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW = CW + 1;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [PW-1:0]     rd_q, rd_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DATA_W-1:0] head_q, head_d;
  logic [DATA_W-1:0] tail_q, tail_d;
  logic [DATA_W-1:0] nxt_q;

  logic [PW-1:0]     rd_inc, rd_inc2, wr_ptr, raddr;
  logic [SW-1:0]     wr_sum, wr_wrap;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    rd_inc  = ptr_inc(rd_q);
    rd_inc2 = ptr_inc(rd_inc);
    wr_sum  = SW'(rd_q) + SW'(cnt_q);
    wr_wrap = (wr_sum >= SW'(DEPTH)) ? wr_sum - SW'(DEPTH) : wr_sum;
    wr_ptr  = wr_wrap[PW-1:0];
    // keep nxt_q on the entry behind the head
    raddr   = cmd_i.pop ? rd_inc2 : rd_inc;
  end

  always_comb begin
    rd_d   = rd_q;
    cnt_d  = cnt_q;
    head_d = head_q;
    tail_d = tail_q;
    if (cmd_i.push) begin
      cnt_d  = cnt_q + CW'(1);
      tail_d = cmd_i.data;
      if (cnt_q == '0) begin
        head_d = cmd_i.data;
      end
    end else if (cmd_i.pop) begin
      cnt_d  = cnt_q - CW'(1);
      rd_d   = rd_inc;
      head_d = nxt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_ptr] <= cmd_i.data;
    end
    // forward a write to the prefetched slot
    if (cmd_i.push && (wr_ptr == raddr)) begin
      nxt_q <= cmd_i.data;
    end else begin
      nxt_q <= mem[raddr];
    end
  end

  assign count_o      = cnt_q;
  assign count_next_o = cnt_d;
  assign ends_o       = '{head: head_q, tail: tail_q};
  assign ends_next_o  = '{head: head_d, tail: tail_d};

endmodule

### rtl/core/balanced_dual_fifo.sv
`timescale 1ns / 1ps

// balanced pair of byte queues behind one stream interface
// input beat: tuser = kind (0 enqueue, 1 dequeue), tdata = byte to enqueue
// an enqueue goes to the shorter queue (A on a tie) and is dropped with the
// rejected flag only when both queues are full; a dequeue pops the longer
// queue (A on a tie) and returns 45 with the rejected flag when both are empty
// every output beat reports the value, both sizes and the head and tail byte
// of each queue after the operation, 45 standing for an empty queue
// one input beat gives exactly one output beat, registered and valid in the cycle after acceptance
// throughput is one beat per cycle unless the output stalls: each queue does
// one counter update and at most one storage write per cycle, and a prefetch
// register behind the head keeps the next head byte ready for a pop
// the output beat sits in a register; while it is stalled a new input beat is
// still taken in the same cycle the receiver takes the held one
// reset empties both queues and drops any held output beat; storage contents
// are not cleared and need no clearing pass
module balanced_dual_fifo #(
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // value_in
  input  logic        s_axis_tuser_i,   // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // value_out, size_a, size_b, front_a, back_a, front_b, back_b
  output logic [47:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o    // served_queue, rejected
);
  import bdf_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic          accept;
  kind_e         kind;
  q_cmd_t        cmd_a, cmd_b;
  logic [CW-1:0] cnt_a, cnt_b, cnt_a_d, cnt_b_d;
  q_ends_t       ends_a, ends_b, ends_a_d, ends_b_d;

  logic              served, rejected;
  logic [DATA_W-1:0] vout;
  logic [CW+SIZE_W-1:0] size_a_ext, size_b_ext;

  logic      valid_q, valid_d;
  res_data_t res_q, res_d;
  logic [1:0] user_q, user_d;

  assign s_axis_tready_o = !valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign kind            = kind_e'(s_axis_tuser_i);

  always_comb begin
    cmd_a    = '{push: 1'b0, pop: 1'b0, data: s_axis_tdata_i};
    cmd_b    = '{push: 1'b0, pop: 1'b0, data: s_axis_tdata_i};
    served   = QUEUE_A;
    rejected = 1'b0;
    vout     = '0;
    unique case (kind)
      KIND_ENQ: begin
        if (cnt_a <= cnt_b) begin
          // a tie with A full means both are full
          if (cnt_a >= CW'(DEPTH)) begin
            rejected = 1'b1;
          end else begin
            cmd_a.push = accept;
          end
        end else begin
          served     = QUEUE_B;
          cmd_b.push = accept;
        end
      end
      KIND_DEQ: begin
        if ((cnt_a == '0) && (cnt_b == '0)) begin
          rejected = 1'b1;
          vout     = DASH_CODE;
        end else if (cnt_a >= cnt_b) begin
          cmd_a.pop = accept;
          vout      = ends_a.head;
        end else begin
          served    = QUEUE_B;
          cmd_b.pop = accept;
          vout      = ends_b.head;
        end
      end
      default: ;
    endcase
  end

  bdf_queue #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_queue_a (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_a),
    .count_o      (cnt_a),
    .count_next_o (cnt_a_d),
    .ends_o       (ends_a),
    .ends_next_o  (ends_a_d)
  );

  bdf_queue #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_queue_b (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_b),
    .count_o      (cnt_b),
    .count_next_o (cnt_b_d),
    .ends_o       (ends_b),
    .ends_next_o  (ends_b_d)
  );

  always_comb begin
    size_a_ext        = {{SIZE_W{1'b0}}, cnt_a_d};
    size_b_ext        = {{SIZE_W{1'b0}}, cnt_b_d};
    res_d.value_out   = vout;
    res_d.size_a      = size_a_ext[SIZE_W-1:0];
    res_d.size_b      = size_b_ext[SIZE_W-1:0];
    res_d.front_a     = (cnt_a_d == '0) ? DASH_CODE : ends_a_d.head;
    res_d.back_a      = (cnt_a_d == '0) ? DASH_CODE : ends_a_d.tail;
    res_d.front_b     = (cnt_b_d == '0) ? DASH_CODE : ends_b_d.head;
    res_d.back_b      = (cnt_b_d == '0) ? DASH_CODE : ends_b_d.tail;
    user_d            = {rejected, served};
  end

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q  <= res_d;
      user_q <= user_d;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = res_q;
  assign m_axis_tuser_o  = user_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a <= CW'(DEPTH)) && (cnt_b <= CW'(DEPTH)))
    else $error("queue count above depth");

  // shortest-queue enqueue and longest-queue dequeue keep sizes within one
  a_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cnt_a} <= {1'b0, cnt_b} + (CW+1)'(1)) &&
    ({1'b0, cnt_b} <= {1'b0, cnt_a} + (CW+1)'(1)))
    else $error("queue sizes out of balance");

  a_one_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_a.push, cmd_a.pop, cmd_b.push, cmd_b.pop}) <= 1)
    else $error("more than one queue operation in a cycle");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid_o)
    else $error("accepted beat gave no result");

endmodule
